// File: src/jacobi_stencil_sweep_core_assert.svh
// Assertion macros used by the stencil sweep port checker.
`ifndef JACOBI_STENCIL_SWEEP_CORE_ASSERT_SVH
`define JACOBI_STENCIL_SWEEP_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define JSS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stencil sweep check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define JSS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stencil sweep check failed");

`endif

// File: src/jss_pkg.sv
// Shared constants, register codes and structs of the stencil sweep block.
`timescale 1ns / 1ps
package jss_pkg;

    localparam int MAX_ROWS_DEF   = 1024;
    localparam int MAX_COLS_DEF   = 1024;

    localparam int DATA_W         = 32;
    localparam int CFG_W          = 11;
    localparam int CHG_W          = 31;
    localparam int SUM_W          = DATA_W + 2;
    localparam int DIFF_W         = DATA_W + 1;
    localparam int APB_W          = 32;
    localparam int APB_ADDR_W     = 4;

    // Output queue depth; keep it a power of two so the pointers wrap freely.
    localparam int OUT_FIFO_DEPTH = 8;
    localparam int PTR_W          = $clog2(OUT_FIFO_DEPTH);

    localparam logic [CFG_W-1:0] GRID_ROWS_RST = CFG_W'(1024);
    localparam logic [CFG_W-1:0] GRID_COLS_RST = CFG_W'(1024);
    localparam logic [CHG_W-1:0] START_MAX_RST = '0;
    localparam logic [CHG_W-1:0] CHG_SAT       = '1;

    typedef enum logic [1:0] {
        REG_GRID_ROWS = 2'd0,
        REG_GRID_COLS = 2'd1,
        REG_START_MAX = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] grid_rows;
        logic [CFG_W-1:0] grid_cols;
        logic [CHG_W-1:0] start_max_change;
    } cfg_t;

    // One accepted sample with its four neighbours and its position flags.
    typedef struct packed {
        logic                     valid;
        logic                     interior;
        logic                     last;
        logic                     restart;
        logic signed [DATA_W-1:0] up;
        logic signed [DATA_W-1:0] left;
        logic signed [DATA_W-1:0] center;
        logic signed [DATA_W-1:0] right;
        logic signed [DATA_W-1:0] below;
    } taps_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] new_value;
        logic [CHG_W-1:0]         max_change;
        logic                     last_point;
    } result_t;

endpackage

// File: src/jss_stream_if.sv
// Valid/ready stream interfaces for grid samples and averaged points.
`timescale 1ns / 1ps
interface jss_in_if;
    import jss_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink (input valid, input cell_value, output ready);
endinterface

interface jss_out_if;
    import jss_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] new_value;
    logic [CHG_W-1:0]         max_change;
    logic                     last_point;

    modport source (output valid, output new_value, output max_change, output last_point,
                    input ready);
    modport sink (input valid, input new_value, input max_change, input last_point,
                  output ready);
endinterface

// File: src/jss_apb_regs.sv
// APB register bank: grid size and start value of the running maximum.
`timescale 1ns / 1ps
module jss_apb_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [jss_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [jss_pkg::APB_W-1:0]      pwdata,
    output logic [jss_pkg::APB_W-1:0]      prdata,
    output logic                           pready,
    output jss_pkg::cfg_t                  cfg
);
    import jss_pkg::*;

    logic [CFG_W-1:0] grid_rows_reg, grid_rows_next;
    logic [CFG_W-1:0] grid_cols_reg, grid_cols_next;
    logic [CHG_W-1:0] start_max_reg, start_max_next;
    logic             wr_en;
    reg_idx_t         idx;

    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        grid_rows_next = grid_rows_reg;
        grid_cols_next = grid_cols_reg;
        start_max_next = start_max_reg;
        if (wr_en)
        begin
            case (idx)
                REG_GRID_ROWS: grid_rows_next = pwdata[CFG_W-1:0];
                REG_GRID_COLS: grid_cols_next = pwdata[CFG_W-1:0];
                REG_START_MAX: start_max_next = pwdata[CHG_W-1:0];
                default:       grid_rows_next = grid_rows_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= GRID_ROWS_RST;
            grid_cols_reg <= GRID_COLS_RST;
            start_max_reg <= START_MAX_RST;
        end
        else
        begin
            grid_rows_reg <= grid_rows_next;
            grid_cols_reg <= grid_cols_next;
            start_max_reg <= start_max_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_GRID_ROWS: prdata = APB_W'(grid_rows_reg);
            REG_GRID_COLS: prdata = APB_W'(grid_cols_reg);
            REG_START_MAX: prdata = APB_W'(start_max_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.grid_rows        = grid_rows_reg;
    assign cfg.grid_cols        = grid_cols_reg;
    assign cfg.start_max_change = start_max_reg;

endmodule

// File: src/jss_line_store.sv
// Raster counters, the two line memories and the middle-row window.
`timescale 1ns / 1ps
module jss_line_store #(
    parameter int MAX_ROWS = jss_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = jss_pkg::MAX_COLS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  jss_pkg::cfg_t                    cfg,
    input  logic                             accept,
    input  logic signed [jss_pkg::DATA_W-1:0] cell_value,
    output jss_pkg::taps_t                   taps
);
    import jss_pkg::*;

    localparam int LINE_DEPTH = MAX_COLS + 2;
    localparam int LW         = $clog2(LINE_DEPTH);
    localparam int RW         = $clog2(MAX_ROWS + 2);

    logic signed [DATA_W-1:0] upper_mem  [LINE_DEPTH];
    logic signed [DATA_W-1:0] middle_mem [LINE_DEPTH];
    logic signed [DATA_W-1:0] upper_rd_reg;
    logic signed [DATA_W-1:0] middle_rd_reg;
    logic signed [DATA_W-1:0] win1_reg;
    logic signed [DATA_W-1:0] win2_reg;
    logic signed [DATA_W-1:0] mid0_reg;
    logic signed [DATA_W-1:0] cur_w0, cur_w1;

    logic [LW-1:0] col_reg, col_next, col_inc, cols_eff, col_last, mid_raddr;
    logic [LW:0]   mid_raddr_wide;
    logic [RW-1:0] row_reg, row_next, rows_eff, row_last;
    logic          col_wrap;

    // Clamp the programmed sizes to 1..MAX.
    always_comb
    begin
        if (cfg.grid_cols == '0)
            cols_eff = LW'(1);
        else if (32'(cfg.grid_cols) > MAX_COLS)
            cols_eff = LW'(MAX_COLS);
        else
            cols_eff = LW'(cfg.grid_cols);

        if (cfg.grid_rows == '0)
            rows_eff = RW'(1);
        else if (32'(cfg.grid_rows) > MAX_ROWS)
            rows_eff = RW'(MAX_ROWS);
        else
            rows_eff = RW'(cfg.grid_rows);
    end

    assign col_last = cols_eff + LW'(1);
    assign row_last = rows_eff + RW'(1);
    assign col_wrap = (col_reg >= col_last);
    assign col_inc  = col_reg + LW'(1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = (row_reg >= row_last) ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Read ahead for the next sample's column; the right neighbour sits one entry on.
    assign mid_raddr_wide = {1'b0, col_next} + (LW + 1)'(1);
    assign mid_raddr      = (mid_raddr_wide >= (LW + 1)'(LINE_DEPTH)) ? '0
                                                                       : mid_raddr_wide[LW-1:0];

    // Window view for the current column; column zero restarts from the row head.
    assign cur_w0 = (col_reg == '0) ? '0 : win1_reg;
    assign cur_w1 = (col_reg == '0) ? mid0_reg : win2_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
            upper_mem[col_reg] <= cur_w1;
        upper_rd_reg <= upper_mem[col_next];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            middle_mem[col_reg] <= cell_value;
        middle_rd_reg <= middle_mem[mid_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win1_reg <= cur_w1;
            win2_reg <= middle_rd_reg;
            if (col_reg == '0)
                mid0_reg <= cell_value;
        end
    end

    assign taps.valid    = accept;
    assign taps.interior = (row_reg >= RW'(2)) && (row_reg <= row_last)
                           && (col_reg != '0) && (col_reg <= cols_eff);
    assign taps.last     = (row_reg == row_last) && (col_reg == cols_eff);
    assign taps.restart  = (row_reg == '0) && (col_reg == '0);
    assign taps.up       = upper_rd_reg;
    assign taps.left     = cur_w0;
    assign taps.center   = cur_w1;
    assign taps.right    = middle_rd_reg;
    assign taps.below    = cell_value;

endmodule

// File: src/jss_datapath.sv
// Stencil average, absolute change and running maximum, two register stages.
`timescale 1ns / 1ps
module jss_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  jss_pkg::taps_t              taps,
    input  logic [jss_pkg::CHG_W-1:0]   start_max_change,
    output logic                        push,
    output jss_pkg::result_t            push_word
);
    import jss_pkg::*;

    logic                     s1_valid_reg, s1_valid_next;
    logic                     s1_restart_reg, s1_last_reg;
    logic signed [SUM_W-1:0]  s1_sum_reg;
    logic signed [DATA_W-1:0] s1_center_reg;

    logic                     s2_valid_reg, s2_restart_reg, s2_last_reg;
    logic signed [DATA_W-1:0] s2_q_reg;
    logic signed [DIFF_W-1:0] s2_diff_reg;

    logic signed [DATA_W-1:0] q;
    logic [DIFF_W-1:0]        mag;
    logic [CHG_W-1:0]         chg;
    logic [CHG_W-1:0]         run_max_reg, run_max_next;

    // Only interior points and the sweep-start marker travel down the pipe.
    assign s1_valid_next = taps.valid && (taps.interior || taps.restart);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            run_max_reg  <= START_MAX_RST;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
            run_max_reg  <= run_max_next;
        end
    end

    // Floor of sum / 4 is the arithmetic shift, the top bits of the sum.
    assign q = $signed(s1_sum_reg[SUM_W-1:2]);

    always_ff @(posedge clk)
    begin
        s1_restart_reg <= taps.restart;
        s1_last_reg    <= taps.last;
        s1_sum_reg     <= SUM_W'(taps.up) + SUM_W'(taps.left)
                        + SUM_W'(taps.right) + SUM_W'(taps.below);
        s1_center_reg  <= taps.center;

        s2_restart_reg <= s1_restart_reg;
        s2_last_reg    <= s1_last_reg;
        s2_q_reg       <= q;
        s2_diff_reg    <= DIFF_W'(q) - DIFF_W'(s1_center_reg);
    end

    // Magnitude of the change, saturated to the field.
    assign mag = s2_diff_reg[DIFF_W-1] ? DIFF_W'(-s2_diff_reg) : DIFF_W'(s2_diff_reg);
    assign chg = (|mag[DIFF_W-1:CHG_W]) ? CHG_SAT : mag[CHG_W-1:0];

    always_comb
    begin
        run_max_next = run_max_reg;
        if (s2_valid_reg)
        begin
            if (s2_restart_reg)
                run_max_next = start_max_change;
            else if (chg > run_max_reg)
                run_max_next = chg;
        end
    end

    assign push                 = s2_valid_reg && !s2_restart_reg;
    assign push_word.new_value  = s2_q_reg;
    assign push_word.max_change = run_max_next;
    assign push_word.last_point = s2_last_reg;

endmodule

// File: src/jss_out_fifo.sv
// Output queue with credit count: a slot is booked when an interior point enters.
`timescale 1ns / 1ps
module jss_out_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             reserve,
    input  logic             push,
    input  jss_pkg::result_t push_word,
    input  logic             pop,
    output logic             can_take,
    output logic             out_valid,
    output jss_pkg::result_t out_word
);
    import jss_pkg::*;

    result_t          fifo_mem [OUT_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic [PTR_W:0]   credit_reg, credit_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;

        case ({push, pop})
            2'b10:   count_next = count_reg + (PTR_W + 1)'(1);
            2'b01:   count_next = count_reg - (PTR_W + 1)'(1);
            default: count_next = count_reg;
        endcase

        case ({reserve, pop})
            2'b10:   credit_next = credit_reg + (PTR_W + 1)'(1);
            2'b01:   credit_next = credit_reg - (PTR_W + 1)'(1);
            default: credit_next = credit_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            credit_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            credit_reg <= credit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= push_word;
    end

    assign can_take  = (credit_reg < (PTR_W + 1)'(OUT_FIFO_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_word  = fifo_mem[rd_ptr_reg];

endmodule

// File: src/jacobi_stencil_sweep_core.sv
// Top level of the Jacobi 4-point stencil sweep over a streamed Q16.16 grid.
`timescale 1ns / 1ps
// Usage:
//   samples : sink channel, one signed Q16.16 word per handshake, the grid in
//             raster order with its one-cell halo, (rows+2) x (cols+2) words.
//   results : source channel, one word per interior point: the floor average
//             of its four neighbours, the running maximum absolute change of
//             the sweep so far (saturating) and a mark on the final point.
//   APB     : grid_rows at 0x0, grid_cols at 0x4, start_max_change at 0x8;
//             write only between sweeps, with the block drained.
// Throughput is one word per cycle while a queue slot can still be booked, set
// by the single pass over each line memory (one write and one read-ahead of the
// next column per cycle). A result is built from the sample below its point in
// order: memory taps and sum into s1, then average and change into s2, then the
// running maximum into an eight-word output queue.
// A stalled receiver does not stall the pipe; samples keeps taking words until
// the queue slots booked by interior points in flight run out.
// Reset clears the raster counters, the queue and the running maximum; the
// line memories need no clearing, their entries are written before use.
module jacobi_stencil_sweep_core #(
    parameter int MAX_ROWS = jss_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = jss_pkg::MAX_COLS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    jss_in_if.sink                         samples,
    jss_out_if.source                      results,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [jss_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [jss_pkg::APB_W-1:0]      pwdata,
    output logic [jss_pkg::APB_W-1:0]      prdata,
    output logic                           pready
);
    import jss_pkg::*;

    cfg_t    cfg;
    taps_t   taps;
    result_t push_word;
    result_t out_word;
    logic    accept;
    logic    can_take;
    logic    push;
    logic    pop;
    logic    out_valid;

    // Register bank.
    jss_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Take a sample whenever a queue slot can still be booked.
    assign samples.ready = can_take;
    assign accept        = samples.valid && can_take;

    // Line memories present the four neighbours of the point above the sample.
    jss_line_store #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_lines (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .accept     (accept),
        .cell_value (samples.cell_value),
        .taps       (taps)
    );

    jss_datapath u_math (
        .clk              (clk),
        .rst_n            (rst_n),
        .taps             (taps),
        .start_max_change (cfg.start_max_change),
        .push             (push),
        .push_word        (push_word)
    );

    // Book a slot per interior point on entry; free it when the word leaves.
    assign pop = out_valid && results.ready;

    jss_out_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .reserve   (accept && taps.interior),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .can_take  (can_take),
        .out_valid (out_valid),
        .out_word  (out_word)
    );

    assign results.valid      = out_valid;
    assign results.new_value  = out_word.new_value;
    assign results.max_change = out_word.max_change;
    assign results.last_point = out_word.last_point;

endmodule

// File: src/jss_checker.sv
// Port-level checks of the stencil sweep core, bound to the top level.
`timescale 1ns / 1ps
`include "jacobi_stencil_sweep_core_assert.svh"
module jss_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [jss_pkg::APB_ADDR_W-1:0] paddr,
    input logic [jss_pkg::APB_W-1:0]      pwdata,
    input logic [jss_pkg::APB_W-1:0]      prdata
);
    import jss_pkg::*;

    logic rows_wr;
    logic rows_rd;

    assign rows_wr = psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == REG_GRID_ROWS);
    assign rows_rd = psel && !pwrite && (paddr[APB_ADDR_W-1:2] == REG_GRID_ROWS);

    // A waiting result word stays offered.
    `JSS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)

    // An empty queue fills only with a point whose last sample came in and passed s1 and s2 into the queue.
    `JSS_ASSERT_IMP(a_out_latency, $rose(out_valid), $past(in_valid && in_ready, 3))

    // Input backpressure only arises from results piling up at the output.
    `JSS_ASSERT_IMP(a_stall_cause, !in_ready, out_valid)

    // A grid_rows write reads back on the next cycle.
    `JSS_ASSERT_IMP(a_rows_readback, rows_wr ##1 rows_rd, prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0]))

endmodule

bind jacobi_stencil_sweep_core jss_checker u_jss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);

// File: dv/jacobi_stencil_sweep_core_checker.sv
// Stencil sweep checker: predicts each averaged point and compares result words.
`timescale 1ns / 1ps
module jacobi_stencil_sweep_core_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    jss_in_if                              smp,
    jss_out_if                             res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [jss_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [jss_pkg::APB_W-1:0]      pwdata,
    input  logic                           pready,
    output int                             errors,
    output int                             pending
);
    import jss_pkg::*;

    localparam int LINE_LEN = MAX_COLS_DEF + 2;

    cfg_t                     cfg;
    logic signed [DATA_W-1:0] line_above [LINE_LEN];
    logic signed [DATA_W-1:0] line_mid [LINE_LEN];
    logic signed [DATA_W-1:0] win [3];
    logic [CFG_W-1:0]         row_idx;
    logic [CFG_W-1:0]         col_idx;
    logic [CHG_W-1:0]         run_max;
    result_t                  point_q [$];

    function automatic int grid_extent(input logic [CFG_W-1:0] v, input int top_v);
        if (v == '0)
            return 1;
        if (int'(v) > top_v)
            return top_v;
        return int'(v);
    endfunction

    // Advance the raster position by one sample; flag an averaged point if it is interior.
    task automatic average_cell(input logic signed [DATA_W-1:0] sample_in, output bit hit,
                                output result_t pt);
        int                       rows;
        int                       cols;
        int                       r;
        int                       c;
        logic signed [DATA_W-1:0] up;
        logic signed [SUM_W-1:0]  total;
        logic signed [DATA_W-1:0] avg;
        logic signed [DIFF_W-1:0] delta;
        logic [DIFF_W-1:0]        mag;
        logic [CHG_W-1:0]         chg;
        rows = grid_extent(cfg.grid_rows, MAX_ROWS_DEF);
        cols = grid_extent(cfg.grid_cols, MAX_COLS_DEF);
        r    = int'(row_idx);
        c    = int'(col_idx);
        up   = (c < LINE_LEN) ? line_above[c] : '0;
        hit  = 1'b0;
        pt   = '0;

        if (r == 0 && c == 0)
            run_max = cfg.start_max_change;

        if (c == 0)
        begin
            win[0] = '0;
            win[1] = line_mid[0];
            win[2] = line_mid[1];
        end
        else
        begin
            win[0] = win[1];
            win[1] = win[2];
            win[2] = (c + 1 < LINE_LEN) ? line_mid[c + 1] : '0;
        end

        if (r >= 2 && r <= rows + 1 && c >= 1 && c <= cols)
        begin
            total = SUM_W'(up) + SUM_W'(win[0]) + SUM_W'(win[2]) + SUM_W'(sample_in);
            avg   = DATA_W'(total >>> 2);
            delta = DIFF_W'(avg) - DIFF_W'(win[1]);
            mag   = (delta < 0) ? -delta : delta;
            chg   = (mag > {2'b00, CHG_SAT}) ? CHG_SAT : mag[CHG_W-1:0];
            if (chg > run_max)
                run_max = chg;
            pt.new_value  = avg;
            pt.max_change = run_max;
            pt.last_point = (r == rows + 1 && c == cols);
            hit = 1'b1;
        end

        if (c < LINE_LEN)
        begin
            line_above[c] = win[1];
            line_mid[c]   = sample_in;
        end

        if (c >= cols + 1)
        begin
            col_idx = '0;
            row_idx = (r >= rows + 1) ? '0 : CFG_W'(r + 1);
        end
        else
        begin
            col_idx = CFG_W'(c + 1);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        result_t want;
        result_t pred;
        bit      hit;
        if (!rst_n)
        begin
            cfg.grid_rows        = GRID_ROWS_RST;
            cfg.grid_cols        = GRID_COLS_RST;
            cfg.start_max_change = START_MAX_RST;
            row_idx = '0;
            col_idx = '0;
            win     = '{default: '0};
            run_max = START_MAX_RST;
            point_q.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (point_q.size() == 0)
                begin
                    $error("unexpected result word: new_value %h", res.new_value);
                    errors++;
                end
                else
                begin
                    want = point_q.pop_front();
                    if (res.new_value !== want.new_value)
                    begin
                        $error("new_value expected %h actual %h", want.new_value, res.new_value);
                        errors++;
                    end
                    if (res.max_change !== want.max_change)
                    begin
                        $error("max_change expected %h actual %h", want.max_change,
                               res.max_change);
                        errors++;
                    end
                    if (res.last_point !== want.last_point)
                    begin
                        $error("last_point expected %b actual %b", want.last_point,
                               res.last_point);
                        errors++;
                    end
                end
            end

            if (smp.valid && smp.ready)
            begin
                average_cell(smp.cell_value, hit, pred);
                if (hit)
                    point_q.push_back(pred);
            end

            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_GRID_ROWS: cfg.grid_rows        = pwdata[CFG_W-1:0];
                    REG_GRID_COLS: cfg.grid_cols        = pwdata[CFG_W-1:0];
                    REG_START_MAX: cfg.start_max_change = pwdata[CHG_W-1:0];
                    default: ;
                endcase
            end

            pending = point_q.size();
        end
    end

endmodule

// File: dv/jacobi_stencil_sweep_core_test.sv
// Stimulus, handshake pacing and verdict for the stencil sweep block.
`timescale 1ns / 1ps
module jacobi_stencil_sweep_core_test;
    import jss_pkg::*;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFFFFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh80000000;

    // Random part: about this many grid words across small sweeps.
    localparam int RANDOM_CELLS  = 400;
    // Long receiver hold, long enough to fill the eight-word output queue many times over.
    localparam int HOLD_CYCLES   = 400;
    // Settle time after the last expected word: the pipe stages plus margin,
    // covering the bottom-right halo word that makes no result.
    localparam int DRAIN_CYCLES  = 12;
    // Cycles with no word moving on either channel before giving up. The slowest
    // correct stretch is the receiver hold or a register phase; the sender gap and
    // receiver stall are each shorter.
    localparam int STALL_LIMIT   = 4000;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_W-1:0]      pwdata;
    logic [APB_W-1:0]      prdata;
    logic                  pready;

    int mismatches;
    int in_flight;
    int cells_sent;
    int burst_left;
    int idle_cycles;
    bit hold_req;
    bit hold_done;

    jss_in_if  smp ();
    jss_out_if res ();

    jacobi_stencil_sweep_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (smp),
        .results (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // The checker watches both channels and the register bus on its own.
    jacobi_stencil_sweep_core_checker stencil_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .smp     (smp),
        .res     (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .pready  (pready),
        .errors  (mismatches),
        .pending (in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: count cycles in which no word moves on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((smp.valid && smp.ready) || (res.valid && res.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Result side: ready runs of random length broken by short stalls, sometimes
    // none at all, plus one long hold when the stimulus asks for it.
    initial
    begin : result_sink
        int run_left;
        int stall_left;
        res.ready  = 1'b0;
        run_left   = 0;
        stall_left = 0;
        hold_done  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                // Hold ready low while the sender keeps offering words; the block
                // must fill its queue and push back on the sample channel.
                res.ready <= 1'b0;
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (run_left > 0)
            begin
                res.ready <= 1'b1;
                run_left--;
            end
            else if (stall_left > 0)
            begin
                res.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res.ready <= 1'b1;
                run_left   = $urandom_range(1, 48);
                stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
        end
    end

    // Pick a grid word: extremes now and then, mostly close values so the running
    // maximum keeps moving, and full-range noise so every bit toggles.
    function automatic logic signed [DATA_W-1:0] rand_cell();
        case ($urandom_range(0, 9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3, 4, 5, 6: return $signed(32'($urandom_range(0, 32'h000F_FFFF))) - 32'sh0008_0000;
            default: return $urandom;
        endcase
    endfunction

    // Clamp a size register the way the block reads it.
    function automatic int grid_extent(input logic [CFG_W-1:0] v, input int top_v);
        if (v == '0)
            return 1;
        if (int'(v) > top_v)
            return top_v;
        return int'(v);
    endfunction

    // One register write: setup cycle, then access until pready.
    task automatic apb_write(input reg_idx_t idx, input logic [APB_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Load all three registers; unused upper data bits carry noise.
    task automatic program_grid(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
                                input logic [CHG_W-1:0] start_chg);
        apb_write(REG_GRID_ROWS, (32'($urandom) & ~32'h7FF) | 32'(rows));
        apb_write(REG_GRID_COLS, (32'($urandom) & ~32'h7FF) | 32'(cols));
        apb_write(REG_START_MAX, {1'($urandom), start_chg});
    endtask

    // Offer one grid word. Bursts of random length alternate with random gaps;
    // keep valid high across a burst, drop it only for a gap.
    task automatic send_cell(input logic signed [DATA_W-1:0] v);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                smp.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        smp.valid      <= 1'b1;
        smp.cell_value <= v;
        do @(posedge clk); while (!smp.ready);
        @(negedge clk);
        burst_left--;
        cells_sent++;
    endtask

    // Stream whole sweeps of random words, halo included.
    task automatic send_grid(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
                             input int sweeps);
        int nr;
        int nc;
        nr = grid_extent(rows, MAX_ROWS_DEF);
        nc = grid_extent(cols, MAX_COLS_DEF);
        repeat (sweeps)
            for (int r = 0; r < nr + 2; r++)
                for (int c = 0; c < nc + 2; c++)
                    send_cell(rand_cell());
    endtask

    // Drop valid, wait for every expected word, then let the pipe settle.
    task automatic wait_idle();
        smp.valid <= 1'b0;
        while (in_flight != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin : stimulus
        // 1 x 2 interior. First point: all neighbours at the negative extreme under
        // a positive-extreme center, so the change saturates. Second point: a
        // negative sum that is not a multiple of four, so the shift rounds down.
        logic signed [DATA_W-1:0] pair_grid [12];
        // 1 x 1 interior: positive-extreme neighbours around a negative-extreme
        // center, the opposite saturation, on the final point of the sweep.
        logic signed [DATA_W-1:0] single_grid [9];
        int                target;
        int                sweep_len;
        int                sweeps;
        logic [CFG_W-1:0]  rows;
        logic [CFG_W-1:0]  cols;
        logic [CHG_W-1:0]  start_chg;

        pair_grid = '{
            32'sh0, Q_MIN, Q_MIN, 32'sh0,
            Q_MIN,  Q_MAX, Q_MIN, Q_MIN,
            32'sh0, Q_MIN, Q_MIN, 32'sh0
        };
        single_grid = '{
            32'sh0, Q_MAX, 32'sh0,
            Q_MAX,  Q_MIN, Q_MAX,
            32'sh0, Q_MAX, 32'sh0
        };
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        smp.valid      = 1'b0;
        smp.cell_value = '0;
        hold_req       = 1'b0;
        burst_left     = 0;
        cells_sent     = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: both saturation directions, floor rounding, last mark,
        // running maximum from zero and from its top value, sizes of zero.
        program_grid(CFG_W'(1), CFG_W'(2), '0);
        foreach (pair_grid[i]) send_cell(pair_grid[i]);
        wait_idle();
        program_grid('0, '0, CHG_SAT);
        foreach (single_grid[i]) send_cell(single_grid[i]);
        wait_idle();

        // Mid-size grid; the receiver holds off early on so the sample side
        // must back up.
        hold_req = 1'b1;
        program_grid(CFG_W'(6), CFG_W'(8), CFG_W'($urandom_range(0, 32'h0000_FFFF)));
        send_grid(CFG_W'(6), CFG_W'(8), 1);
        wait_idle();

        // Random small sweeps: sizes, start values and word mix all vary.
        target = cells_sent + RANDOM_CELLS;
        while (cells_sent < target)
        begin
            case ($urandom_range(0, 9))
                0: rows = '0;
                1, 2: rows = CFG_W'($urandom_range(7, 16));
                default: rows = CFG_W'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 9))
                0: cols = '0;
                1, 2: cols = CFG_W'($urandom_range(9, 24));
                default: cols = CFG_W'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 4))
                0, 1: start_chg = '0;
                2: start_chg = CHG_SAT;
                default: start_chg = CHG_W'($urandom_range(0, 32'h0004_0000));
            endcase
            sweep_len = (grid_extent(rows, MAX_ROWS_DEF) + 2)
                      * (grid_extent(cols, MAX_COLS_DEF) + 2);
            sweeps    = $urandom_range(1, 3);
            // Fewer sweeps when little of the word budget is left.
            while (sweeps > 1 && cells_sent + sweeps * sweep_len > target)
                sweeps--;
            program_grid(rows, cols, start_chg);
            send_grid(rows, cols, sweeps);
            wait_idle();
        end

        if (mismatches == 0 && in_flight == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
